@@ design/rv32id_pkg.sv @@
// shared constants and types for the rv32im instruction decoder
`default_nettype none

package rv32id_pkg;

    // major opcodes
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;

    // exact system words, compared whole in the first stage
    localparam logic [31:0] WORD_MRET   = 32'h3020_0073;
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_NOP    = 32'h0000_0001;

    // funct7 codes of the register alu words
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 codes with special alu meaning
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SRL = 3'd5;

    typedef enum logic [3:0] {
        ALU_ADD   = 4'd0,
        ALU_SUB   = 4'd1,
        ALU_SLT   = 4'd2,
        ALU_SLTU  = 4'd3,
        ALU_XOR   = 4'd4,
        ALU_OR    = 4'd5,
        ALU_AND   = 4'd6,
        ALU_SLL   = 4'd7,
        ALU_SRL   = 4'd8,
        ALU_SRA   = 4'd9,
        ALU_LUI   = 4'd10,
        ALU_AUIPC = 4'd11
    } t_alu_op;

    // opcode and word matches found in the first stage
    typedef struct packed {
        logic opc_reg;
        logic opc_imm;
        logic opc_load;
        logic opc_jalr;
        logic opc_store;
        logic opc_branch;
        logic opc_lui;
        logic opc_auipc;
        logic opc_jal;
        logic opc_system;
        logic opc_fence;
        logic f7_base;
        logic f7_alt;
        logic mret;
        logic ecall;
        logic ebreak;
        logic nop;
    } t_hits;

    // flag groups built in the second stage
    typedef struct packed {
        t_alu_op     alu_op;
        logic [5:0]  fmt;
        logic [11:0] cls;
        logic [3:0]  sys;
        logic [3:0]  ctl;
    } t_flags;

    // alu operation of a base register word, by funct3
    function automatic t_alu_op base_op(input logic [2:0] f3);
        t_alu_op op;
        case (f3)
            3'd0: op = ALU_ADD;
            3'd1: op = ALU_SLL;
            3'd2: op = ALU_SLT;
            3'd3: op = ALU_SLTU;
            3'd4: op = ALU_XOR;
            3'd5: op = ALU_SRL;
            3'd6: op = ALU_OR;
            3'd7: op = ALU_AND;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ design/rv32im_instruction_decoder_unit.sv @@
// rv32im instruction decoder: three stage pipeline from word to decoded fields
// pipeline: three register stages; an input transfer passes through stage one,
// stage two and the output register before it can leave on the result side
// throughput: one instruction per cycle; each stage holds while the next is full
// and stalled, so a stall on the result side backs up without loss
// reset: synchronous active low, clears the stage valid bits only
`default_nettype none

module rv32im_instruction_decoder_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_instruction,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [16:0]             o_raw_fields,
    output logic [14:0]             o_register_indices,
    output logic signed [11:0]      o_imm_itype,
    output logic signed [11:0]      o_imm_stype,
    output logic signed [12:0]      o_imm_btype,
    output logic [19:0]             o_imm_utype,
    output logic signed [20:0]      o_imm_jtype,
    output logic [3:0]              o_alu_operation,
    output logic [5:0]              o_format_flags,
    output logic [11:0]             o_class_flags,
    output logic [3:0]              o_system_flags,
    output logic [3:0]              o_control_flags
);
    import rv32id_pkg::*;

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_word1, r_word2;
    t_hits       r_hits, n_hits;
    t_flags      r_flags, n_flags;
    logic        en1, en2, en3;

    // stage advance: a stage loads when it is empty or its content moves on
    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready  = en1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage one: opcode, funct7 and exact word compares
    always_comb begin
        n_hits.opc_reg    = i_instruction[6:0] == OPC_REG;
        n_hits.opc_imm    = i_instruction[6:0] == OPC_IMM;
        n_hits.opc_load   = i_instruction[6:0] == OPC_LOAD;
        n_hits.opc_jalr   = i_instruction[6:0] == OPC_JALR;
        n_hits.opc_store  = i_instruction[6:0] == OPC_STORE;
        n_hits.opc_branch = i_instruction[6:0] == OPC_BRANCH;
        n_hits.opc_lui    = i_instruction[6:0] == OPC_LUI;
        n_hits.opc_auipc  = i_instruction[6:0] == OPC_AUIPC;
        n_hits.opc_jal    = i_instruction[6:0] == OPC_JAL;
        n_hits.opc_system = i_instruction[6:0] == OPC_SYSTEM;
        n_hits.opc_fence  = i_instruction[6:0] == OPC_FENCE;
        n_hits.f7_base    = i_instruction[31:25] == F7_BASE;
        n_hits.f7_alt     = i_instruction[31:25] == F7_ALT;
        n_hits.mret       = i_instruction == WORD_MRET;
        n_hits.ecall      = i_instruction == WORD_ECALL;
        n_hits.ebreak     = i_instruction == WORD_EBREAK;
        n_hits.nop        = i_instruction == WORD_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_word1 <= i_instruction;
            r_hits  <= n_hits;
        end
    end

    // stage two: flag groups and alu operation
    always_comb begin
        logic [2:0] f3;
        logic       m_ext;
        logic       is_r, is_mul, is_div, wr;
        f3     = r_word1[14:12];
        m_ext  = r_word1[25];
        is_r   = r_hits.opc_reg && !m_ext;
        is_mul = r_hits.opc_reg && m_ext && !f3[2];
        is_div = r_hits.opc_reg && m_ext && f3[2];

        n_flags.fmt = {r_hits.opc_jal, r_hits.opc_lui || r_hits.opc_auipc,
                       r_hits.opc_branch, r_hits.opc_store, r_hits.opc_imm, is_r};

        n_flags.cls = {r_hits.opc_fence, is_div, is_mul, r_hits.opc_system,
                       r_hits.opc_branch, r_hits.opc_imm, is_r, r_hits.opc_store,
                       r_hits.opc_load, r_hits.opc_auipc, r_hits.opc_lui,
                       r_hits.opc_jalr};

        n_flags.sys = {r_hits.nop, r_hits.ebreak, r_hits.ecall, r_hits.mret};

        // register write is dropped for rd zero
        wr = (r_hits.opc_reg || r_hits.opc_imm || r_hits.opc_lui || r_hits.opc_auipc ||
              r_hits.opc_jal || r_hits.opc_jalr || r_hits.opc_load ||
              r_hits.opc_system) && (r_word1[11:7] != 5'd0);
        n_flags.ctl = {f3 >= 3'd5, r_hits.opc_store, r_hits.opc_load, wr};

        // alu operation select
        if (r_hits.opc_lui) begin
            n_flags.alu_op = ALU_LUI;
        end else if (r_hits.opc_auipc) begin
            n_flags.alu_op = ALU_AUIPC;
        end else if (r_hits.opc_reg) begin
            if (r_hits.f7_base) begin
                n_flags.alu_op = base_op(f3);
            end else if (r_hits.f7_alt && f3 == F3_ADD) begin
                n_flags.alu_op = ALU_SUB;
            end else if (r_hits.f7_alt && f3 == F3_SRL) begin
                n_flags.alu_op = ALU_SRA;
            end else begin
                n_flags.alu_op = ALU_ADD;
            end
        end else if (r_hits.opc_imm) begin
            if (f3 == F3_SLL) begin
                n_flags.alu_op = ALU_SLL;
            end else if (f3 == F3_SRL) begin
                n_flags.alu_op = r_word1[30] ? ALU_SRA : ALU_SRL;
            end else begin
                n_flags.alu_op = base_op(f3);
            end
        end else begin
            n_flags.alu_op = ALU_ADD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_word2 <= r_word1;
            r_flags <= n_flags;
        end
    end

    // stage three: output register with field and immediate extraction
    always_ff @(posedge i_clk) begin
        if (en3) begin
            o_raw_fields       <= {r_word2[31:25], r_word2[14:12], r_word2[6:0]};
            o_register_indices <= {r_word2[24:20], r_word2[19:15], r_word2[11:7]};
            o_imm_itype        <= r_word2[31:20];
            o_imm_stype        <= {r_word2[31:25], r_word2[11:7]};
            o_imm_btype        <= {r_word2[31], r_word2[7], r_word2[30:25],
                                   r_word2[11:8], 1'b0};
            o_imm_utype        <= r_word2[31:12];
            o_imm_jtype        <= {r_word2[31], r_word2[19:12], r_word2[20],
                                   r_word2[30:21], 1'b0};
            o_alu_operation    <= r_flags.alu_op;
            o_format_flags     <= r_flags.fmt;
            o_class_flags      <= r_flags.cls;
            o_system_flags     <= r_flags.sys;
            o_control_flags    <= r_flags.ctl;
        end
    end

endmodule

`default_nettype wire

@@ sim/rv32im_instruction_decoder_checker.sv @@
// checker for the rv32im instruction decoder: predicts each decoded result and compares it
`timescale 1ns / 100ps

module rv32im_instruction_decoder_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [31:0]        i_instruction,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [16:0]        i_raw_fields,
    input  wire logic [14:0]        i_register_indices,
    input  wire logic signed [11:0] i_imm_itype,
    input  wire logic signed [11:0] i_imm_stype,
    input  wire logic signed [12:0] i_imm_btype,
    input  wire logic [19:0]        i_imm_utype,
    input  wire logic signed [20:0] i_imm_jtype,
    input  wire logic [3:0]         i_alu_operation,
    input  wire logic [5:0]         i_format_flags,
    input  wire logic [11:0]        i_class_flags,
    input  wire logic [3:0]         i_system_flags,
    input  wire logic [3:0]         i_control_flags,
    output int                      o_fail_count,
    output int                      o_pending
);
    import rv32id_pkg::*;

    typedef struct {
        logic [16:0]        raw;
        logic [14:0]        regs;
        logic signed [11:0] imm_i;
        logic signed [11:0] imm_s;
        logic signed [12:0] imm_b;
        logic [19:0]        imm_u;
        logic signed [20:0] imm_j;
        t_alu_op            alu;
        logic [5:0]         fmt;
        logic [11:0]        cls;
        logic [3:0]         sys;
        logic [3:0]         ctl;
    } t_decoded;

    t_decoded decoded_q[$];
    int       mismatches = 0;

    // plain arithmetic operation selected by funct3 alone
    function automatic t_alu_op funct3_alu_op(input logic [2:0] f3);
        t_alu_op op;
        case (f3)
            3'd1:    op = ALU_SLL;
            3'd2:    op = ALU_SLT;
            3'd3:    op = ALU_SLTU;
            3'd4:    op = ALU_XOR;
            3'd5:    op = ALU_SRL;
            3'd6:    op = ALU_OR;
            3'd7:    op = ALU_AND;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

    // full decode of one instruction word
    function automatic t_decoded decode_word(input logic [31:0] w);
        t_decoded   d;
        logic [6:0] opc;
        logic [6:0] f7;
        logic [2:0] f3;
        logic       is_r, is_i, is_s, is_b, is_u, is_j, m_ext, mul, dvd, wr;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];

        d.raw   = {f7, f3, opc};
        d.regs  = {w[24:20], w[19:15], w[11:7]};
        d.imm_i = w[31:20];
        d.imm_s = {w[31:25], w[11:7]};
        d.imm_b = {w[31], w[7], w[30:25], w[11:8], 1'b0};
        d.imm_u = w[31:12];
        d.imm_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};

        // alu operation
        if (opc == OPC_LUI)
            d.alu = ALU_LUI;
        else if (opc == OPC_AUIPC)
            d.alu = ALU_AUIPC;
        else if (opc == OPC_REG) begin
            if (f7 == F7_BASE)
                d.alu = funct3_alu_op(f3);
            else if (f7 == F7_ALT && f3 == F3_ADD)
                d.alu = ALU_SUB;
            else if (f7 == F7_ALT && f3 == F3_SRL)
                d.alu = ALU_SRA;
            else
                d.alu = ALU_ADD;
        end else if (opc == OPC_IMM) begin
            if (f3 == F3_SLL)
                d.alu = ALU_SLL;
            else if (f3 == F3_SRL)
                d.alu = w[30] ? ALU_SRA : ALU_SRL;
            else
                d.alu = funct3_alu_op(f3);
        end else
            d.alu = ALU_ADD;

        // format and unit class
        m_ext = f7[0];
        is_r  = (opc == OPC_REG) && !m_ext;
        is_i  = (opc == OPC_IMM);
        is_s  = (opc == OPC_STORE);
        is_b  = (opc == OPC_BRANCH);
        is_u  = (opc == OPC_LUI) || (opc == OPC_AUIPC);
        is_j  = (opc == OPC_JAL);
        mul   = (opc == OPC_REG) && m_ext && !f3[2];
        dvd   = (opc == OPC_REG) && m_ext && f3[2];
        d.fmt = {is_j, is_u, is_b, is_s, is_i, is_r};
        d.cls = {opc == OPC_FENCE, dvd, mul, opc == OPC_SYSTEM, is_b, is_i, is_r, is_s,
                 opc == OPC_LOAD, opc == OPC_AUIPC, opc == OPC_LUI, opc == OPC_JALR};

        // exact system words
        d.sys = {w == WORD_NOP, w == WORD_EBREAK, w == WORD_ECALL, w == WORD_MRET};

        // control: register write is dropped when rd is x0
        wr = (opc == OPC_REG) || (opc == OPC_IMM) || (opc == OPC_LUI) ||
             (opc == OPC_AUIPC) || (opc == OPC_JAL) || (opc == OPC_JALR) ||
             (opc == OPC_LOAD) || (opc == OPC_SYSTEM);
        if (w[11:7] == 5'd0)
            wr = 1'b0;
        d.ctl = {f3 >= 3'd5, opc == OPC_STORE, opc == OPC_LOAD, wr};
        return d;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // watch both channels, queue predictions and compare results in order
    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                decoded_q.push_back(decode_word(i_instruction));
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result transfer with no instruction outstanding");
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("raw_fields", want.raw, i_raw_fields);
                    check_field("register_indices", want.regs, i_register_indices);
                    check_field("imm_itype", want.imm_i, i_imm_itype);
                    check_field("imm_stype", want.imm_s, i_imm_stype);
                    check_field("imm_btype", want.imm_b, i_imm_btype);
                    check_field("imm_utype", want.imm_u, i_imm_utype);
                    check_field("imm_jtype", want.imm_j, i_imm_jtype);
                    check_field("alu_operation", want.alu, i_alu_operation);
                    check_field("format_flags", want.fmt, i_format_flags);
                    check_field("class_flags", want.cls, i_class_flags);
                    check_field("system_flags", want.sys, i_system_flags);
                    check_field("control_flags", want.ctl, i_control_flags);
                end
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ sim/tb_rv32im_instruction_decoder_unit.sv @@
// testbench top for the rv32im instruction decoder: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_rv32im_instruction_decoder_unit;
    import rv32id_pkg::*;

    // funct codes and an unknown opcode used by the directed words
    localparam logic [6:0] F7_MULDIV   = 7'h01;
    localparam logic [2:0] F3_SLTU     = 3'd3;
    localparam logic [2:0] F3_XOR      = 3'd4;
    localparam logic [2:0] F3_OR       = 3'd6;
    localparam logic [2:0] F3_AND      = 3'd7;
    localparam logic [2:0] F3_CSRRWI   = 3'd5;
    localparam logic [6:0] OPC_UNKNOWN = 7'h7F;

    localparam int BATCH_ITEMS = 634;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] instruction = 32'd0;
    logic        out_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [16:0]        o_raw_fields;
    logic [14:0]        o_register_indices;
    logic signed [11:0] o_imm_itype;
    logic signed [11:0] o_imm_stype;
    logic signed [12:0] o_imm_btype;
    logic [19:0]        o_imm_utype;
    logic signed [20:0] o_imm_jtype;
    logic [3:0]         o_alu_operation;
    logic [5:0]         o_format_flags;
    logic [11:0]        o_class_flags;
    logic [3:0]         o_system_flags;
    logic [3:0]         o_control_flags;

    int fail_count;
    int pending;
    int tx_idle_pct = 21;
    int rx_idle_pct = 52;

    logic [6:0] known_opcodes[11] = '{OPC_REG, OPC_IMM, OPC_LOAD, OPC_JALR, OPC_STORE,
                                      OPC_BRANCH, OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_SYSTEM,
                                      OPC_FENCE};
    logic [31:0] system_words[4] = '{WORD_MRET, WORD_ECALL, WORD_EBREAK, WORD_NOP};

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rv32im_instruction_decoder_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_instruction      (instruction),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_raw_fields       (o_raw_fields),
        .o_register_indices (o_register_indices),
        .o_imm_itype        (o_imm_itype),
        .o_imm_stype        (o_imm_stype),
        .o_imm_btype        (o_imm_btype),
        .o_imm_utype        (o_imm_utype),
        .o_imm_jtype        (o_imm_jtype),
        .o_alu_operation    (o_alu_operation),
        .o_format_flags     (o_format_flags),
        .o_class_flags      (o_class_flags),
        .o_system_flags     (o_system_flags),
        .o_control_flags    (o_control_flags)
    );

    rv32im_instruction_decoder_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (o_in_ready),
        .i_instruction      (instruction),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .i_raw_fields       (o_raw_fields),
        .i_register_indices (o_register_indices),
        .i_imm_itype        (o_imm_itype),
        .i_imm_stype        (o_imm_stype),
        .i_imm_btype        (o_imm_btype),
        .i_imm_utype        (o_imm_utype),
        .i_imm_jtype        (o_imm_jtype),
        .i_alu_operation    (o_alu_operation),
        .i_format_flags     (o_format_flags),
        .i_class_flags      (o_class_flags),
        .i_system_flags     (o_system_flags),
        .i_control_flags    (o_control_flags),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [31:0] encode(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // one instruction transfer, with random idle cycles ahead of it
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        instruction <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // hold the sender off until every result has come back
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // mostly well-formed words with random content, some noise and system words
    task automatic send_random_batch(input int count);
        logic [31:0] w;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            w    = $urandom;
            if (pick < 6) begin
                w = system_words[$urandom_range(3)];
            end else if (pick < 9) begin
                // near miss of an exact system word
                w = system_words[$urandom_range(3)] ^ (32'd1 << $urandom_range(31));
            end else if (pick >= 18) begin
                w[6:0] = known_opcodes[$urandom_range(10)];
                if (w[6:0] == OPC_REG) begin
                    case ($urandom_range(3))
                        0: w[31:25] = F7_BASE;
                        1: w[31:25] = F7_ALT;
                        2: w[31:25] = F7_MULDIV;
                        default: ;
                    endcase
                end else if (w[6:0] == OPC_IMM && $urandom_range(1) == 1) begin
                    w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
                end
                if ($urandom_range(7) == 0)
                    w[11:7] = 5'd0;
            end
            send_word(w);
        end
    endtask

    // stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words: extremes, every class and the special cases
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(WORD_MRET);
        send_word(WORD_ECALL);
        send_word(WORD_EBREAK);
        send_word(WORD_NOP);
        send_word(encode(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_REG));
        send_word(encode(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd0, OPC_REG));
        send_word(encode(F7_ALT, 5'd5, 5'd6, F3_SRL, 5'd7, OPC_REG));
        send_word(encode(F7_ALT, 5'd1, 5'd2, F3_XOR, 5'd4, OPC_REG));
        send_word(encode(F7_MULDIV, 5'd1, 5'd2, F3_ADD, 5'd5, OPC_REG));
        send_word(encode(F7_MULDIV, 5'd1, 5'd2, F3_AND, 5'd6, OPC_REG));
        send_word(encode(7'h7F, 5'd9, 5'd10, F3_OR, 5'd11, OPC_REG));
        send_word(encode(F7_ALT, 5'd3, 5'd4, F3_SLL, 5'd8, OPC_IMM));
        send_word(encode(F7_ALT, 5'd31, 5'd4, F3_SRL, 5'd9, OPC_IMM));
        send_word(encode(F7_BASE, 5'd31, 5'd4, F3_SRL, 5'd9, OPC_IMM));
        send_word({12'hFFF, 5'd12, F3_SLTU, 5'd0, OPC_IMM});
        send_word({20'h80000, 5'd31, OPC_LUI});
        send_word({20'h7FFFF, 5'd1, OPC_AUIPC});
        send_word({20'hFFFFF, 5'd1, OPC_JAL});
        send_word(encode(F7_BASE, 5'd0, 5'd1, F3_ADD, 5'd1, OPC_JALR));
        send_word({12'h800, 5'd2, 3'($urandom_range(7)), 5'd14, OPC_LOAD});
        send_word(encode(7'h7F, 5'd15, 5'd16, F3_XOR, 5'h1F, OPC_STORE));
        send_word(encode(7'h40, 5'd17, 5'd18, F3_AND, 5'h01, OPC_BRANCH));
        send_word(encode(F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_FENCE));
        send_word(encode(7'h18, 5'd0, 5'd21, F3_CSRRWI, 5'd22, OPC_SYSTEM));
        send_word(encode(7'h55, 5'd23, 5'd24, F3_OR, 5'd25, OPC_UNKNOWN));
        drain();

        // random words under three flow control settings
        send_random_batch(BATCH_ITEMS);
        drain();
        tx_idle_pct = 52;
        rx_idle_pct = 21;
        send_random_batch(BATCH_ITEMS);
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_batch(BATCH_ITEMS);
        drain();

        // let any stray result surface past the pipeline depth
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ rv32im_instruction_decoder_unit.f @@
design/rv32id_pkg.sv
design/rv32im_instruction_decoder_unit.sv
sim/rv32im_instruction_decoder_checker.sv
sim/tb_rv32im_instruction_decoder_unit.sv
